// ----- src/phil_pkg.sv -----
package phil_pkg;

    // Hash function selector codes
    localparam logic [2:0] FN_MULT_SHIFT_R   = 3'd0;
    localparam logic [2:0] FN_MULT_SHIFT_RX  = 3'd1;
    localparam logic [2:0] FN_MULSHROLATE1RX = 3'd2;
    localparam logic [2:0] FN_MULSHROLATE2RX = 3'd3;
    localparam logic [2:0] FN_MULSHROLATE3RX = 3'd4;
    localparam logic [2:0] FN_MULSHROLATE4RX = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_FUNCTION_SELECT   = 3'd0;
    localparam logic [2:0] REG_MULTIPLIER_A      = 3'd1;
    localparam logic [2:0] REG_MULTIPLIER_B      = 3'd2;
    localparam logic [2:0] REG_SHIFT_CONTROL     = 3'd3;
    localparam logic [2:0] REG_POST_MULTIPLIER_A = 3'd4;
    localparam logic [2:0] REG_POST_MULTIPLIER_B = 3'd5;
    localparam logic [2:0] REG_VERTEX_MASK       = 3'd6;
    localparam logic [2:0] REG_RESULT_MASK       = 3'd7;

    // Item kinds on the input stream
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_COLLISION   = 2'd1;
    localparam logic [1:0] STATUS_WRITE_DONE  = 2'd2;

    typedef struct packed {
        logic [2:0]  function_select;
        logic [31:0] multiplier_a;
        logic [31:0] multiplier_b;
        logic [31:0] shift_control;
        logic [31:0] post_multiplier_a;
        logic [31:0] post_multiplier_b;
        logic [31:0] vertex_mask;
        logic [31:0] result_mask;
    } phil_cfg_t;

    // Per-stage control that travels with each word
    typedef struct packed {
        logic valid;
        logic is_write;
        logic collision;
    } phil_ctrl_t;

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] r);
        return (v >> r) | (v << (6'd32 - 6'(r)));
    endfunction

    function automatic logic [31:0] shr32(input logic [31:0] v, input logic [7:0] s);
        return (s >= 8'd32) ? 32'd0 : (v >> s);
    endfunction

endpackage

// ----- src/phil_table.sv -----
module phil_table
    import phil_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  logic [ENTRY_WIDTH-1:0]         wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_b,
    output logic [ENTRY_WIDTH-1:0]         rd_data_a,
    output logic [ENTRY_WIDTH-1:0]         rd_data_b
);

    logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_a_reg;
    logic [ENTRY_WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- src/phil_hash.sv -----
module phil_hash
    import phil_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  phil_cfg_t                      cfg,
    input  logic                           in_valid,
    input  logic                           in_is_write,
    input  logic [31:0]                    in_key,
    input  logic [$clog2(TABLE_DEPTH)-1:0] in_wr_addr,
    input  logic [ENTRY_WIDTH-1:0]         in_wr_value,
    output phil_ctrl_t                     out_ctrl,
    output logic [$clog2(TABLE_DEPTH)-1:0] out_addr_a,
    output logic [$clog2(TABLE_DEPTH)-1:0] out_addr_b,
    output logic [$clog2(TABLE_DEPTH)-1:0] out_wr_addr,
    output logic [ENTRY_WIDTH-1:0]         out_wr_value
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [2:0] fs;
    logic [7:0] sh;
    logic [7:0] r1;
    logic [7:0] r2;

    phil_ctrl_t c1_reg, c2_reg, c3_reg, c4_reg;
    phil_ctrl_t c1_next, c4_next;
    logic [AW-1:0]          wa1_reg, wa2_reg, wa3_reg, wa4_reg;
    logic [ENTRY_WIDTH-1:0] wv1_reg, wv2_reg, wv3_reg, wv4_reg;

    logic [31:0] prod_a_reg, prod_b_reg, prod_a_next, prod_b_next;
    logic [31:0] rot_a_reg, rot_b_reg, rot_a_next, rot_b_next;
    logic [31:0] post_a_reg, post_b_reg, post_a_next, post_b_next;
    logic [31:0] v1_next, v2_next;
    logic [AW-1:0] addr_a_reg, addr_b_reg;

    assign fs = cfg.function_select;
    assign sh = cfg.shift_control[15:8];
    assign r1 = cfg.shift_control[23:16];
    assign r2 = cfg.shift_control[31:24];

    // Stage 1: seed multiplies, low 32 bits kept
    assign c1_next     = '{valid: in_valid, is_write: in_is_write, collision: 1'b0};
    assign prod_a_next = in_key * cfg.multiplier_a;
    assign prod_b_next = in_key * cfg.multiplier_b;

    // Stage 2: rotates, mod 32
    always_comb begin
        rot_a_next = prod_a_reg;
        rot_b_next = prod_b_reg;
        if (fs inside {FN_MULSHROLATE1RX, FN_MULSHROLATE2RX,
                       FN_MULSHROLATE3RX, FN_MULSHROLATE4RX}) begin
            rot_a_next = ror32(prod_a_reg, r1[4:0]);
        end
        if (fs inside {FN_MULSHROLATE2RX, FN_MULSHROLATE3RX, FN_MULSHROLATE4RX}) begin
            rot_b_next = ror32(prod_b_reg, r2[4:0]);
        end
    end

    // Stage 3: post multiplies
    always_comb begin
        post_a_next = rot_a_reg;
        post_b_next = rot_b_reg;
        if (fs inside {FN_MULSHROLATE3RX, FN_MULSHROLATE4RX}) begin
            post_a_next = rot_a_reg * cfg.post_multiplier_a;
        end
        if (fs == FN_MULSHROLATE4RX) begin
            post_b_next = rot_b_reg * cfg.post_multiplier_b;
        end
    end

    // Stage 4: shifts, masking (FN_MULT_SHIFT_R only) and the collision test on full vertices
    always_comb begin
        case (fs)
            FN_MULT_SHIFT_R: begin
                v1_next = shr32(post_a_reg, sh) & cfg.vertex_mask;
                v2_next = shr32(post_b_reg, r1) & cfg.vertex_mask;
            end
            FN_MULT_SHIFT_RX, FN_MULSHROLATE1RX, FN_MULSHROLATE2RX,
            FN_MULSHROLATE3RX, FN_MULSHROLATE4RX: begin
                v1_next = shr32(post_a_reg, sh);
                v2_next = shr32(post_b_reg, sh);
            end
            default: begin
                v1_next = 32'd0;
                v2_next = 32'd0;
            end
        endcase
        c4_next           = c3_reg;
        c4_next.collision = !c3_reg.is_write && (v1_next == v2_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end else if (en) begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            rot_a_reg  <= rot_a_next;
            rot_b_reg  <= rot_b_next;
            post_a_reg <= post_a_next;
            post_b_reg <= post_b_next;
            addr_a_reg <= v1_next[AW-1:0];
            addr_b_reg <= v2_next[AW-1:0];
            wa1_reg    <= in_wr_addr;
            wa2_reg    <= wa1_reg;
            wa3_reg    <= wa2_reg;
            wa4_reg    <= wa3_reg;
            wv1_reg    <= in_wr_value;
            wv2_reg    <= wv1_reg;
            wv3_reg    <= wv2_reg;
            wv4_reg    <= wv3_reg;
        end
    end

    assign out_ctrl     = c4_reg;
    assign out_addr_a   = addr_a_reg;
    assign out_addr_b   = addr_b_reg;
    assign out_wr_addr  = wa4_reg;
    assign out_wr_value = wv4_reg;

endmodule

// ----- src/perfect_hash_index_lookup.sv -----
// Two-vertex perfect-hash lookup. Each input word is either a lookup (tuser 0) or a
// table write (tuser 1); every word yields exactly one result word, in order. A lookup
// hashes the key with the selected multiply/shift/rotate function into two vertices,
// reads both table entries and returns (entry_a + entry_b) & result_mask with status
// OK, or 0 with status COLLISION when the two 32-bit vertices are equal (function
// selects 6 and 7 always collide). A write stores entry_value at entry_address and
// returns 0 with status WRITE DONE. Throughput is one word per clock while the output
// register is free; from input acceptance a word passes four hash stages (seed multiply,
// rotate, post multiply, shift and compare), the registered read of the two-read,
// one-write vertex table, and the output register. Writes reach the table in the same
// stage where lookups read it, so words behind a write see the new value without any
// forwarding. The whole pipeline advances only while the output register is empty
// or being taken; it stalls as one. Table entries power up undefined and must be
// written before they are looked up. Configuration writes are taken at any time
// (cfg_ready is tied high) and must only be issued while the block is idle.
module perfect_hash_index_lookup
    import phil_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16,
    parameter int TABLE_DEPTH = 4096,
    parameter int KEY_WIDTH   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [43:32] entry_address, [59:44] entry_value
    input  logic [0:0]  s_tuser,   // [0] opcode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] slot_index
    output logic [1:0]  m_tuser,   // [1:0] status
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    phil_cfg_t cfg_reg;

    logic                   en;
    logic [31:0]            key_used;
    logic [AW-1:0]          in_wr_addr;
    logic [ENTRY_WIDTH-1:0] in_wr_value;

    phil_ctrl_t             c4;
    logic [AW-1:0]          addr_a, addr_b, wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_value;
    logic [ENTRY_WIDTH-1:0] rd_a, rd_b;

    phil_ctrl_t  c5_reg;
    logic        out_valid_reg;
    logic [31:0] slot_reg, slot_next;
    logic [1:0]  status_reg, status_next;

    // Advance the whole pipeline when the output register is free or being drained
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Keep the low key bits; fold the write address onto the table
    assign key_used    = 32'(s_tdata[KEY_WIDTH-1:0]);
    assign in_wr_addr  = AW'(s_tdata[43:32]);
    assign in_wr_value = ENTRY_WIDTH'(s_tdata[59:44]);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.function_select   <= FN_MULT_SHIFT_R;
            cfg_reg.multiplier_a      <= 32'd1;
            cfg_reg.multiplier_b      <= 32'd1;
            cfg_reg.shift_control     <= 32'd0;
            cfg_reg.post_multiplier_a <= 32'd1;
            cfg_reg.post_multiplier_b <= 32'd1;
            cfg_reg.vertex_mask       <= 32'd4095;
            cfg_reg.result_mask       <= 32'd4095;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FUNCTION_SELECT:   cfg_reg.function_select   <= cfg_data[2:0];
                REG_MULTIPLIER_A:      cfg_reg.multiplier_a      <= cfg_data;
                REG_MULTIPLIER_B:      cfg_reg.multiplier_b      <= cfg_data;
                REG_SHIFT_CONTROL:     cfg_reg.shift_control     <= cfg_data;
                REG_POST_MULTIPLIER_A: cfg_reg.post_multiplier_a <= cfg_data;
                REG_POST_MULTIPLIER_B: cfg_reg.post_multiplier_b <= cfg_data;
                REG_VERTEX_MASK:       cfg_reg.vertex_mask       <= cfg_data;
                REG_RESULT_MASK:       cfg_reg.result_mask       <= cfg_data;
                default: ;
            endcase
        end
    end

    phil_hash #(
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_is_write  (s_tuser[0] == OP_WRITE),
        .in_key       (key_used),
        .in_wr_addr   (in_wr_addr),
        .in_wr_value  (in_wr_value),
        .out_ctrl     (c4),
        .out_addr_a   (addr_a),
        .out_addr_b   (addr_b),
        .out_wr_addr  (wr_addr),
        .out_wr_value (wr_value)
    );

    // Table stage: writes land here, lookups read both vertices here
    phil_table #(
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (en && c4.valid && c4.is_write),
        .wr_addr   (wr_addr),
        .wr_data   (wr_value),
        .rd_en     (en),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Form the result word
    always_comb begin
        if (c5_reg.is_write) begin
            status_next = STATUS_WRITE_DONE;
            slot_next   = 32'd0;
        end else if (c5_reg.collision) begin
            status_next = STATUS_COLLISION;
            slot_next   = 32'd0;
        end else begin
            status_next = STATUS_OK;
            slot_next   = (32'(rd_a) + 32'(rd_b)) & cfg_reg.result_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c5_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            c5_reg        <= c4;
            out_valid_reg <= c5_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = slot_reg;
    assign m_tuser  = status_reg;

`ifndef ASSERT_OFF
    // Only a successful lookup may carry a non-zero index
    a_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> m_tdata == 32'd0)
        else $error("non-zero index on collision or write result");

    // An empty output register must never hold off the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A table write is never flagged as a collision
    a_write_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        c4.valid && c4.is_write |-> !c4.collision)
        else $error("write word marked as collision");

    // A write held in the stage after the table yields a write-done result when the pipeline advances
    a_write_status: assert property (@(posedge aclk) disable iff (!aresetn)
        c5_reg.valid && c5_reg.is_write && en |=> m_tvalid && m_tuser == STATUS_WRITE_DONE)
        else $error("write word lost its write-done status");
`endif

endmodule
